@@ hw/rtl/lpgf_pkg.sv @@
// Shared types and constants of the line prefix gate filter.
// Used by lpgf_front, lpgf_fifo, lpgf_back and line_prefix_gate_filter_core.
package lpgf_pkg;

    localparam int unsigned MAX_MARKER_LEN = 8;
    localparam int unsigned BYTE_W         = 8;
    localparam int unsigned MARKER_W       = MAX_MARKER_LEN * BYTE_W;
    localparam int unsigned LEN_W          = 4;
    localparam int unsigned CNT_W          = $clog2(MAX_MARKER_LEN);
    localparam int unsigned CFG_IDX_W      = 3;
    localparam int unsigned CFG_DATA_W     = 64;
    localparam int unsigned FIFO_DEPTH     = 2;
    localparam int unsigned FIFO_PTR_W     = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_W     = $clog2(FIFO_DEPTH + 1);

    localparam logic [BYTE_W-1:0] NEWLINE = 8'd10;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MARKER  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_LENGTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DISABLE_MARKER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DISABLE_LENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_PASS   = 3'd4;

    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_COPY  = 2'd1;
    localparam logic [1:0] MODE_DROP  = 2'd2;

    typedef struct packed {
        logic [CNT_W-1:0]    held_count;
        logic [MARKER_W-1:0] held_bytes;
        logic [BYTE_W-1:0]   last_byte;
    } job_t;

endpackage

@@ hw/rtl/lpgf_front.sv @@
// Front end: configuration registers, line classification and prefix holding.
// Depends on lpgf_pkg; emits one job per input item that produces output.
module lpgf_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    input  logic [lpgf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lpgf_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_accept,
    input  logic [lpgf_pkg::BYTE_W-1:0]       in_byte,
    input  logic                              end_of_input,
    output logic                              job_push,
    output lpgf_pkg::job_t                    job
);

    logic [lpgf_pkg::MARKER_W-1:0] enable_marker_reg;
    logic [lpgf_pkg::LEN_W-1:0]    enable_length_reg;
    logic [lpgf_pkg::MARKER_W-1:0] disable_marker_reg;
    logic [lpgf_pkg::LEN_W-1:0]    disable_length_reg;

    logic                          pass_reg, pass_next;
    logic [1:0]                    mode_reg, mode_next;
    logic [lpgf_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [lpgf_pkg::BYTE_W-1:0]   hold_reg [lpgf_pkg::MAX_MARKER_LEN];
    logic                          hold_we;

    logic                          line_end;
    logic [lpgf_pkg::MARKER_W-1:0] marker;
    logic [lpgf_pkg::LEN_W-1:0]    len_raw;
    logic [lpgf_pkg::LEN_W-1:0]    len;
    logic [lpgf_pkg::BYTE_W-1:0]   marker_byte;
    logic [lpgf_pkg::LEN_W-1:0]    count_plus;
    logic [lpgf_pkg::MARKER_W-1:0] hold_flat;

    always_comb begin
        for (int i = 0; i < lpgf_pkg::MAX_MARKER_LEN; i++) begin
            hold_flat[i*lpgf_pkg::BYTE_W +: lpgf_pkg::BYTE_W] = hold_reg[i];
        end
    end

    assign line_end    = end_of_input || (in_byte == lpgf_pkg::NEWLINE);
    assign marker      = pass_reg ? disable_marker_reg : enable_marker_reg;
    assign len_raw     = pass_reg ? disable_length_reg : enable_length_reg;
    assign len         = (len_raw > lpgf_pkg::LEN_W'(lpgf_pkg::MAX_MARKER_LEN))
                         ? lpgf_pkg::LEN_W'(lpgf_pkg::MAX_MARKER_LEN) : len_raw;
    assign marker_byte = marker[count_reg*lpgf_pkg::BYTE_W +: lpgf_pkg::BYTE_W];
    assign count_plus  = lpgf_pkg::LEN_W'(count_reg) + lpgf_pkg::LEN_W'(1);

    always_comb begin
        logic decided;
        logic flag;
        decided        = 1'b0;
        flag           = pass_reg;
        pass_next      = pass_reg;
        mode_next      = mode_reg;
        count_next     = count_reg;
        hold_we        = 1'b0;
        job_push       = 1'b0;
        job.held_count = count_reg;
        job.held_bytes = hold_flat;
        job.last_byte  = in_byte;
        if (in_accept) begin
            case (mode_reg)
                lpgf_pkg::MODE_START: begin
                    if (len == '0) begin
                        decided = 1'b1;
                    end else if (marker_byte == in_byte && count_plus >= len) begin
                        flag    = ~pass_reg;
                        decided = 1'b1;
                    end else if (marker_byte != in_byte || line_end) begin
                        decided = 1'b1;
                    end else begin
                        hold_we    = 1'b1;
                        count_next = count_plus[lpgf_pkg::CNT_W-1:0];
                    end
                    if (decided) begin
                        pass_next  = flag;
                        job_push   = flag;
                        count_next = '0;
                        mode_next  = flag ? lpgf_pkg::MODE_COPY : lpgf_pkg::MODE_DROP;
                    end
                end
                lpgf_pkg::MODE_COPY: begin
                    job_push       = 1'b1;
                    job.held_count = '0;
                end
                default: begin
                end
            endcase
            if (line_end) begin
                mode_next  = lpgf_pkg::MODE_START;
                count_next = '0;
            end
        end
        if (cfg_valid && cfg_index == lpgf_pkg::REG_INITIAL_PASS) begin
            pass_next = cfg_data[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_marker_reg  <= '0;
            enable_length_reg  <= '0;
            disable_marker_reg <= '0;
            disable_length_reg <= '0;
            pass_reg           <= 1'b0;
            mode_reg           <= lpgf_pkg::MODE_START;
            count_reg          <= '0;
        end else begin
            pass_reg  <= pass_next;
            mode_reg  <= mode_next;
            count_reg <= count_next;
            if (cfg_valid) begin
                case (cfg_index)
                    lpgf_pkg::REG_ENABLE_MARKER:  enable_marker_reg  <= cfg_data;
                    lpgf_pkg::REG_ENABLE_LENGTH:
                        enable_length_reg <= cfg_data[lpgf_pkg::LEN_W-1:0];
                    lpgf_pkg::REG_DISABLE_MARKER: disable_marker_reg <= cfg_data;
                    lpgf_pkg::REG_DISABLE_LENGTH:
                        disable_length_reg <= cfg_data[lpgf_pkg::LEN_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (hold_we) begin
            hold_reg[count_reg] <= in_byte;
        end
    end

endmodule

@@ hw/rtl/lpgf_fifo.sv @@
// Short job queue between the front end and the output sequencer.
// Depends on lpgf_pkg for the job type and depth.
module lpgf_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  lpgf_pkg::job_t push_job,
    input  logic           pop,
    output lpgf_pkg::job_t head_job,
    output logic           empty,
    output logic           full
);

    lpgf_pkg::job_t                  mem_reg [lpgf_pkg::FIFO_DEPTH];
    logic [lpgf_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [lpgf_pkg::FIFO_CNT_W-1:0] fill_reg;

    assign empty    = (fill_reg == '0);
    assign full     = (fill_reg == lpgf_pkg::FIFO_CNT_W'(lpgf_pkg::FIFO_DEPTH));
    assign head_job = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   fill_reg <= fill_reg + 1'b1;
                2'b01:   fill_reg <= fill_reg - 1'b1;
                default: fill_reg <= fill_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

@@ hw/rtl/lpgf_back.sv @@
// Output sequencer: replays held prefix bytes and the deciding byte of each job.
// Depends on lpgf_pkg; drives the registered result channel.
module lpgf_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        job_avail,
    input  lpgf_pkg::job_t              head_job,
    output logic                        job_pop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [lpgf_pkg::BYTE_W-1:0] m_out_byte,
    output logic                        m_last_of_run
);

    logic                          active_reg;
    logic [lpgf_pkg::CNT_W-1:0]    remain_reg;
    logic [lpgf_pkg::MARKER_W-1:0] held_reg;
    logic [lpgf_pkg::BYTE_W-1:0]   last_reg;
    logic                          final_beat;

    assign final_beat    = (remain_reg == '0);
    assign m_valid       = active_reg;
    assign m_out_byte    = final_beat ? last_reg : held_reg[lpgf_pkg::BYTE_W-1:0];
    assign m_last_of_run = final_beat;
    assign job_pop       = job_avail && (!active_reg || (m_ready && final_beat));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            remain_reg <= '0;
        end else if (job_pop) begin
            active_reg <= 1'b1;
            remain_reg <= head_job.held_count;
        end else if (active_reg && m_ready) begin
            if (final_beat) begin
                active_reg <= 1'b0;
            end else begin
                remain_reg <= remain_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (job_pop) begin
            held_reg <= head_job.held_bytes;
            last_reg <= head_job.last_byte;
        end else if (active_reg && m_ready && !final_beat) begin
            held_reg <= held_reg >> lpgf_pkg::BYTE_W;
        end
    end

endmodule

@@ hw/rtl/line_prefix_gate_filter_core.sv @@
// Top level of the line prefix gate filter: front end, job queue, output sequencer.
// Depends on lpgf_pkg, lpgf_front, lpgf_fifo and lpgf_back.
//
// Passes or drops whole lines of a byte stream, toggling a pass flag when a line
// opens with the enable or disable marker. Input takes one byte per cycle while
// the two-entry job queue has room. Each byte that produces output becomes one
// job; the output sequencer sends one byte per cycle while m_ready is high, so a
// line decided after k held prefix bytes yields k+1 bytes and a copied byte one.
// Configuration writes are taken every cycle (cfg_ready is always high).
module line_prefix_gate_filter_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lpgf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lpgf_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [lpgf_pkg::BYTE_W-1:0]       s_in_byte,
    input  logic                              s_end_of_input,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [lpgf_pkg::BYTE_W-1:0]       m_out_byte,
    output logic                              m_last_of_run
);

    logic           fifo_push;
    logic           fifo_pop;
    logic           fifo_empty;
    logic           fifo_full;
    lpgf_pkg::job_t push_job;
    lpgf_pkg::job_t head_job;

    assign cfg_ready = 1'b1;
    assign s_ready   = !fifo_full;

    lpgf_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_accept    (s_valid && s_ready),
        .in_byte      (s_in_byte),
        .end_of_input (s_end_of_input),
        .job_push     (fifo_push),
        .job          (push_job)
    );

    lpgf_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (fifo_push),
        .push_job (push_job),
        .pop      (fifo_pop),
        .head_job (head_job),
        .empty    (fifo_empty),
        .full     (fifo_full)
    );

    lpgf_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .job_avail     (!fifo_empty),
        .head_job      (head_job),
        .job_pop       (fifo_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last_of_run (m_last_of_run)
    );

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_push |-> (!fifo_full && s_valid))
        else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_pop |-> !fifo_empty)
        else $error("job popped from an empty queue");

    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_of_run) |=> m_valid)
        else $error("result run broken before its last transfer");
`endif

endmodule

@@ verif/testbench.sv @@
// Self-checking bench for line_prefix_gate_filter_core: directed table, then random lines.
// Depends on lpgf_pkg and the core; predicts every output byte and checks it in order.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS_PER_PHASE = 84;
    localparam int SETTLE_CYCLES   = 32;
    localparam int CYCLE_LIMIT     = 100000;

    typedef enum logic [1:0] {OUT_PREDICT, OUT_NONE, OUT_COPY} row_outcome_t;
    typedef enum logic {ROW_XFER, ROW_REG} row_kind_t;

    typedef struct packed {
        logic [lpgf_pkg::BYTE_W-1:0] data;
        logic                        last;
    } out_beat_t;

    typedef struct packed {
        row_kind_t                       kind;
        row_outcome_t                    outcome;
        logic [lpgf_pkg::BYTE_W-1:0]     data;
        logic                            eoi;
        logic [lpgf_pkg::CFG_IDX_W-1:0]  reg_index;
        logic [lpgf_pkg::CFG_DATA_W-1:0] reg_value;
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn;
    logic cfg_valid;
    logic cfg_ready;
    logic [lpgf_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [lpgf_pkg::CFG_DATA_W-1:0] cfg_data;
    logic s_valid;
    logic s_ready;
    logic [lpgf_pkg::BYTE_W-1:0] s_in_byte;
    logic s_end_of_input;
    logic m_valid;
    logic m_ready;
    logic [lpgf_pkg::BYTE_W-1:0] m_out_byte;
    logic m_last_of_run;

    row_outcome_t s_row_outcome;

    int idle_pct;
    int stall_pct;
    int items_sent;
    int error_count;
    int cycle_count;

    // predictor state and its copy of the registers
    logic [lpgf_pkg::MARKER_W-1:0] enable_marker_q;
    logic [lpgf_pkg::LEN_W-1:0]    enable_length_q;
    logic [lpgf_pkg::MARKER_W-1:0] disable_marker_q;
    logic [lpgf_pkg::LEN_W-1:0]    disable_length_q;
    logic                          pass_q;
    logic [1:0]                    mode_q;
    int                            prefix_count_q;
    logic [lpgf_pkg::BYTE_W-1:0]   hold_q[lpgf_pkg::MAX_MARKER_LEN];

    out_beat_t step_beats[lpgf_pkg::MAX_MARKER_LEN];
    out_beat_t pending_output[$];
    stim_row_t directed_rows[$];

    line_prefix_gate_filter_core u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .s_end_of_input (s_end_of_input),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_last_of_run  (m_last_of_run)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    initial begin
        enable_marker_q  = '0;
        enable_length_q  = '0;
        disable_marker_q = '0;
        disable_length_q = '0;
        pass_q           = 1'b0;
        mode_q           = lpgf_pkg::MODE_START;
        prefix_count_q   = 0;
        error_count      = 0;
        cycle_count      = 0;
        items_sent       = 0;
    end

    function automatic void apply_register(input logic [lpgf_pkg::CFG_IDX_W-1:0] idx,
                                           input logic [lpgf_pkg::CFG_DATA_W-1:0] value);
        case (idx)
            lpgf_pkg::REG_ENABLE_MARKER:  enable_marker_q = value;
            lpgf_pkg::REG_ENABLE_LENGTH:  enable_length_q = value[lpgf_pkg::LEN_W-1:0];
            lpgf_pkg::REG_DISABLE_MARKER: disable_marker_q = value;
            lpgf_pkg::REG_DISABLE_LENGTH: disable_length_q = value[lpgf_pkg::LEN_W-1:0];
            lpgf_pkg::REG_INITIAL_PASS:   pass_q = value[0];
            default: ;
        endcase
    endfunction

    // Advance the gate by one byte; fills step_beats and returns how many bytes go out.
    function automatic int gate_byte(input logic [lpgf_pkg::BYTE_W-1:0] b, input logic eoi);
        logic                          line_end;
        logic                          decided;
        logic [lpgf_pkg::MARKER_W-1:0] marker;
        int                            span;
        logic [lpgf_pkg::BYTE_W-1:0]   mb;
        int                            n;
        line_end = eoi || (b == lpgf_pkg::NEWLINE);
        decided  = 1'b0;
        n        = 0;
        if (mode_q == lpgf_pkg::MODE_START) begin
            marker = pass_q ? disable_marker_q : enable_marker_q;
            span   = int'(pass_q ? disable_length_q : enable_length_q);
            if (span > int'(lpgf_pkg::MAX_MARKER_LEN)) span = int'(lpgf_pkg::MAX_MARKER_LEN);
            if (span == 0) begin
                decided = 1'b1;
            end else begin
                mb = marker[8*(prefix_count_q % 8) +: 8];
                if (mb == b && prefix_count_q + 1 >= span) begin
                    pass_q  = ~pass_q;
                    decided = 1'b1;
                end else if (mb != b || line_end) begin
                    decided = 1'b1;
                end else begin
                    hold_q[prefix_count_q % 8] = b;
                    prefix_count_q++;
                end
            end
            if (decided) begin
                if (pass_q) begin
                    for (int i = 0; i < prefix_count_q && i < lpgf_pkg::MAX_MARKER_LEN;
                         i++) begin
                        step_beats[n] = {hold_q[i], 1'b0};
                        n++;
                    end
                    step_beats[n] = {b, 1'b0};
                    n++;
                end
                prefix_count_q = 0;
                mode_q = pass_q ? lpgf_pkg::MODE_COPY : lpgf_pkg::MODE_DROP;
            end
        end else if (mode_q == lpgf_pkg::MODE_COPY) begin
            step_beats[n] = {b, 1'b0};
            n++;
        end
        if (line_end) begin
            mode_q = lpgf_pkg::MODE_START;
            prefix_count_q = 0;
        end
        if (n > 0) step_beats[n-1].last = 1'b1;
        return n;
    endfunction

    function automatic void record_error(input string msg);
        error_count++;
        if (error_count <= 10) $display("%s", msg);
    endfunction

    always @(posedge aclk) begin : scoreboard
        int        n;
        out_beat_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) apply_register(cfg_index, cfg_data);
            if (s_valid && s_ready) begin
                n = gate_byte(s_in_byte, s_end_of_input);
                case (s_row_outcome)
                    OUT_NONE: ;
                    OUT_COPY: pending_output.push_back({s_in_byte, 1'b1});
                    default: begin
                        for (int i = 0; i < n; i++) pending_output.push_back(step_beats[i]);
                    end
                endcase
            end
            if (m_valid && m_ready) begin
                if (pending_output.size() == 0) begin
                    record_error($sformatf("unexpected transfer: byte %02h last %0b",
                                           m_out_byte, m_last_of_run));
                end else begin
                    want = pending_output.pop_front();
                    if (want.data != m_out_byte || want.last != m_last_of_run)
                        record_error($sformatf(
                            "mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                            want.data, want.last, m_out_byte, m_last_of_run));
                end
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic stim_row_t xfer_row(input logic [lpgf_pkg::BYTE_W-1:0] b,
                                           input logic eoi,
                                           input row_outcome_t outcome);
        stim_row_t r;
        r = '0;
        r.kind    = ROW_XFER;
        r.outcome = outcome;
        r.data    = b;
        r.eoi     = eoi;
        return r;
    endfunction

    function automatic stim_row_t reg_row(input logic [lpgf_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [lpgf_pkg::CFG_DATA_W-1:0] value);
        stim_row_t r;
        r = '0;
        r.kind      = ROW_REG;
        r.outcome   = OUT_PREDICT;
        r.reg_index = idx;
        r.reg_value = value;
        return r;
    endfunction

    function automatic logic [lpgf_pkg::MARKER_W-1:0] random_marker();
        logic [lpgf_pkg::MARKER_W-1:0] m;
        logic [lpgf_pkg::BYTE_W-1:0]   c;
        for (int i = 0; i < lpgf_pkg::MAX_MARKER_LEN; i++) begin
            c = lpgf_pkg::BYTE_W'($urandom_range(255));
            if ($urandom_range(15) == 0) c = lpgf_pkg::NEWLINE;
            m[8*i +: 8] = c;
        end
        return m;
    endfunction

    function automatic logic [lpgf_pkg::LEN_W-1:0] random_length();
        logic [lpgf_pkg::LEN_W-1:0] l;
        int                         r;
        r = $urandom_range(15);
        if (r == 0) l = '0;
        else if (r == 1) l = lpgf_pkg::LEN_W'($urandom_range(15, 9));
        else l = lpgf_pkg::LEN_W'($urandom_range(8, 1));
        return l;
    endfunction

    function automatic int marker_span(input logic [lpgf_pkg::LEN_W-1:0] l);
        return (l > lpgf_pkg::LEN_W'(lpgf_pkg::MAX_MARKER_LEN))
               ? int'(lpgf_pkg::MAX_MARKER_LEN) : int'(l);
    endfunction

    task automatic push_byte(input logic [lpgf_pkg::BYTE_W-1:0] b, input logic eoi,
                             input row_outcome_t outcome);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_in_byte      <= b;
        s_end_of_input <= eoi;
        s_row_outcome  <= outcome;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_output.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [lpgf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lpgf_pkg::CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic program_filter(input logic [lpgf_pkg::MARKER_W-1:0] en_m,
                                  input logic [lpgf_pkg::LEN_W-1:0] en_l,
                                  input logic [lpgf_pkg::MARKER_W-1:0] dis_m,
                                  input logic [lpgf_pkg::LEN_W-1:0] dis_l, input logic init);
        wait_idle();
        write_reg(lpgf_pkg::REG_ENABLE_MARKER, en_m);
        write_reg(lpgf_pkg::REG_ENABLE_LENGTH, lpgf_pkg::CFG_DATA_W'(en_l));
        write_reg(lpgf_pkg::REG_DISABLE_MARKER, dis_m);
        write_reg(lpgf_pkg::REG_DISABLE_LENGTH, lpgf_pkg::CFG_DATA_W'(dis_l));
        write_reg(lpgf_pkg::REG_INITIAL_PASS, lpgf_pkg::CFG_DATA_W'(init));
        cfg_valid <= 1'b0;
    endtask

    // Mostly lines that open with a marker, some partial markers, some noise.
    task automatic send_line(input logic [lpgf_pkg::MARKER_W-1:0] en_m, input int en_n,
                             input logic [lpgf_pkg::MARKER_W-1:0] dis_m, input int dis_n);
        logic [lpgf_pkg::BYTE_W-1:0]   line_bytes[$];
        logic [lpgf_pkg::MARKER_W-1:0] m;
        logic [lpgf_pkg::BYTE_W-1:0]   c;
        logic                          use_en;
        logic                          tail_eoi;
        int                            pick;
        int                            n;
        int                            stop;
        pick = $urandom_range(9);
        if (pick < 8) begin
            use_en = (pick < 4) || (pick == 7 && $urandom_range(1) == 0);
            m = use_en ? en_m : dis_m;
            n = use_en ? en_n : dis_n;
            if (pick == 7 && n > 0) n = $urandom_range(n - 1);
            for (int i = 0; i < n; i++) line_bytes.push_back(m[8*i +: 8]);
            repeat ($urandom_range(5)) begin
                c = lpgf_pkg::BYTE_W'($urandom_range(255));
                if (c == lpgf_pkg::NEWLINE) c = 8'h20;
                line_bytes.push_back(c);
            end
        end else begin
            repeat ($urandom_range(12)) begin
                c = lpgf_pkg::BYTE_W'($urandom_range(255));
                line_bytes.push_back(c);
            end
        end
        stop = $urandom_range(9);
        tail_eoi = (stop >= 8);
        if (stop == 9) begin
            c = lpgf_pkg::BYTE_W'($urandom_range(255));
            line_bytes.push_back(c);
        end else begin
            line_bytes.push_back(lpgf_pkg::NEWLINE);
        end
        foreach (line_bytes[i])
            push_byte(line_bytes[i], tail_eoi && (i == line_bytes.size() - 1), OUT_PREDICT);
    endtask

    initial begin
        logic [lpgf_pkg::MARKER_W-1:0] en_m;
        logic [lpgf_pkg::MARKER_W-1:0] dis_m;
        logic [lpgf_pkg::LEN_W-1:0]    en_l;
        logic [lpgf_pkg::LEN_W-1:0]    dis_l;
        logic                          init;
        logic                          paused;
        int                            start;
        stim_row_t                     row;

        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_in_byte      <= '0;
        s_end_of_input <= 1'b0;
        s_row_outcome  <= OUT_PREDICT;
        cfg_valid      <= 1'b0;
        cfg_index      <= lpgf_pkg::REG_ENABLE_MARKER;
        cfg_data       <= '0;
        m_ready        <= 1'b0;
        idle_pct  = 0;
        stall_pct = 0;

        directed_rows.push_back(xfer_row(8'hFF, 1'b0, OUT_NONE));
        directed_rows.push_back(xfer_row(8'h00, 1'b1, OUT_NONE));
        directed_rows.push_back(reg_row(lpgf_pkg::REG_ENABLE_MARKER, 64'h4E4F));
        directed_rows.push_back(reg_row(lpgf_pkg::REG_ENABLE_LENGTH, 64'd2));
        directed_rows.push_back(reg_row(lpgf_pkg::REG_DISABLE_MARKER, 64'h0AFF00));
        directed_rows.push_back(reg_row(lpgf_pkg::REG_DISABLE_LENGTH, 64'd3));
        directed_rows.push_back(xfer_row(8'h4F, 1'b0, OUT_NONE));
        directed_rows.push_back(xfer_row(lpgf_pkg::NEWLINE, 1'b0, OUT_NONE));
        directed_rows.push_back(xfer_row(8'h4F, 1'b0, OUT_NONE));
        directed_rows.push_back(xfer_row(8'h4E, 1'b0, OUT_PREDICT));
        directed_rows.push_back(xfer_row(lpgf_pkg::NEWLINE, 1'b0, OUT_COPY));
        directed_rows.push_back(xfer_row(8'h00, 1'b0, OUT_NONE));
        directed_rows.push_back(xfer_row(lpgf_pkg::NEWLINE, 1'b0, OUT_PREDICT));
        directed_rows.push_back(xfer_row(8'h00, 1'b0, OUT_NONE));
        directed_rows.push_back(xfer_row(8'hFF, 1'b0, OUT_NONE));
        directed_rows.push_back(xfer_row(lpgf_pkg::NEWLINE, 1'b0, OUT_NONE));
        directed_rows.push_back(xfer_row(8'h4F, 1'b0, OUT_NONE));
        directed_rows.push_back(reg_row(lpgf_pkg::REG_INITIAL_PASS, 64'd1));
        directed_rows.push_back(xfer_row(8'h4E, 1'b0, OUT_PREDICT));
        directed_rows.push_back(xfer_row(8'h80, 1'b1, OUT_COPY));
        directed_rows.push_back(reg_row(lpgf_pkg::REG_DISABLE_LENGTH, 64'd0));
        directed_rows.push_back(xfer_row(8'h7F, 1'b0, OUT_COPY));
        directed_rows.push_back(xfer_row(lpgf_pkg::NEWLINE, 1'b0, OUT_COPY));
        directed_rows.push_back(reg_row(lpgf_pkg::REG_ENABLE_MARKER, 64'hAA55_FE01_7F80_FF00));
        directed_rows.push_back(reg_row(lpgf_pkg::REG_ENABLE_LENGTH, 64'd15));
        directed_rows.push_back(reg_row(lpgf_pkg::REG_INITIAL_PASS, 64'd0));
        directed_rows.push_back(xfer_row(8'h00, 1'b0, OUT_NONE));
        directed_rows.push_back(xfer_row(8'hFF, 1'b0, OUT_NONE));
        directed_rows.push_back(xfer_row(8'h80, 1'b0, OUT_NONE));
        directed_rows.push_back(xfer_row(8'h7F, 1'b0, OUT_NONE));
        directed_rows.push_back(xfer_row(8'h01, 1'b0, OUT_NONE));
        directed_rows.push_back(xfer_row(8'hFE, 1'b0, OUT_NONE));
        directed_rows.push_back(xfer_row(8'h55, 1'b0, OUT_NONE));
        directed_rows.push_back(xfer_row(8'hAA, 1'b0, OUT_PREDICT));
        directed_rows.push_back(xfer_row(lpgf_pkg::NEWLINE, 1'b1, OUT_COPY));

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.kind == ROW_REG) begin
                wait_idle();
                write_reg(row.reg_index, row.reg_value);
                cfg_valid <= 1'b0;
            end else begin
                push_byte(row.data, row.eoi, row.outcome);
            end
        end

        for (int p = 0; p < 4; p++) begin
            case (p)
                1: begin idle_pct = 70; stall_pct = 0; end
                2: begin idle_pct = 0; stall_pct = 70; end
                3: begin idle_pct = 30; stall_pct = 30; end
                default: begin idle_pct = 0; stall_pct = 0; end
            endcase
            if (p == 0) begin
                en_m  = '1;
                en_l  = lpgf_pkg::LEN_W'(lpgf_pkg::MAX_MARKER_LEN);
                dis_m = '0;
                dis_l = lpgf_pkg::LEN_W'(lpgf_pkg::MAX_MARKER_LEN);
                init  = 1'b1;
            end else begin
                en_m  = random_marker();
                en_l  = random_length();
                dis_m = random_marker();
                dis_l = random_length();
                init  = 1'($urandom_range(1));
            end
            program_filter(en_m, en_l, dis_m, dis_l, init);
            start  = items_sent;
            paused = 1'b0;
            while (items_sent - start < ITEMS_PER_PHASE) begin
                if (!paused && items_sent - start >= ITEMS_PER_PHASE / 2) begin
                    // hold mid-line until the output side is empty, then write a random pass flag
                    paused = 1'b1;
                    push_byte(en_m[7:0], 1'b0, OUT_PREDICT);
                    wait_idle();
                    write_reg(lpgf_pkg::REG_INITIAL_PASS,
                              lpgf_pkg::CFG_DATA_W'($urandom_range(1)));
                    cfg_valid <= 1'b0;
                end
                send_line(en_m, marker_span(en_l), dis_m, marker_span(dis_l));
            end
        end

        wait_idle();
        if (error_count == 0 && pending_output.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/lpgf_pkg.sv
hw/rtl/lpgf_front.sv
hw/rtl/lpgf_fifo.sv
hw/rtl/lpgf_back.sv
hw/rtl/line_prefix_gate_filter_core.sv
verif/testbench.sv
